// ----- rtl/tvm_pkg.sv -----
// Shared types, constants and command/status structs of the midpoint triangulator.
`default_nettype none

package tvm_pkg;

    localparam int CoefFrac   = 18;
    localparam int RayFrac    = 12;
    localparam int ScaleFrac  = 16;
    localparam int ProdFrac   = 28;

    localparam int SlotW      = 21;
    localparam int CfgW       = 3 * SlotW;
    localparam int PixW       = 16;
    localparam int PointW     = 32;
    localparam int CountW     = 16;
    localparam int RayW       = 30;
    localparam int AccW       = 64;
    localparam int OpW        = 32;
    localparam int NormBits   = 30;

    localparam int RayShift   = CoefFrac + 4 - RayFrac;
    localparam int EfShift    = CoefFrac - 12;
    localparam int PointShift = ProdFrac - ScaleFrac + 1;

    localparam int PixOne      = 16;
    localparam int CenterScale = 1 << (ProdFrac - CoefFrac);

    localparam int NumCfg     = 7;
    localparam int CfgIdxW    = 3;

    // scale divider: integer part limited to DivSatShift bits
    localparam int DivW        = 63;
    localparam int DivSatShift = PointW - 1 - ScaleFrac;
    localparam int DivSteps    = DivSatShift + ScaleFrac;
    localparam int DivCntW     = $clog2(DivSteps + 1);

    localparam logic [CfgIdxW-1:0] REG_RAY_ROW0     = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_RAY_ROW1     = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_RAY_ROW2     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_ROT_RAY_ROW0 = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_ROT_RAY_ROW1 = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_ROT_RAY_ROW2 = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_CENTER       = 3'd6;

    localparam logic [CfgW-1:0] RstRow0 = CfgW'(1) << CoefFrac;
    localparam logic [CfgW-1:0] RstRow1 = CfgW'(1) << (CoefFrac + SlotW);
    localparam logic [CfgW-1:0] RstRow2 = CfgW'(1) << (CoefFrac + 2 * SlotW);

    typedef enum logic [1:0] {
        SEG_GEOM  = 2'd0,
        SEG_SOLVE = 2'd1,
        SEG_POINT = 2'd2
    } t_seg;

    // groups of the geometry segment: six ray components, then Gram terms and centre dot products
    localparam logic [3:0] GRP_GRAM_A = 4'd6;
    localparam logic [3:0] GRP_GRAM_B = 4'd7;
    localparam logic [3:0] GRP_GRAM_C = 4'd8;
    localparam logic [3:0] GRP_DOT_E  = 4'd9;
    localparam logic [3:0] GRP_DOT_F  = 4'd10;
    localparam logic [3:0] GRP_NUM1   = 4'd0;
    localparam logic [3:0] GRP_NUM2   = 4'd1;
    localparam logic [3:0] GRP_DET    = 4'd2;

    localparam logic [3:0] GeomLastGrp  = 4'd10;
    localparam logic [3:0] SolveLastGrp = 4'd2;
    localparam logic [3:0] PointLastGrp = 4'd2;
    localparam logic [1:0] GeomLastTerm  = 2'd2;
    localparam logic [1:0] SolveLastTerm = 2'd1;
    localparam logic [1:0] PointLastTerm = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mac_en;
        logic       wr_en;
        t_seg       seg;
        logic [3:0] grp;
        logic [1:0] term;
        logic       norm_init;
        logic       norm_step;
        logic       neg;
        logic       chk;
        logic       div_start;
        logic       div_sel;
        logic       div_store;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic norm_over;
        logic skip;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/two_view_midpoint_triangulator.sv -----
// Top level of the two-view midpoint triangulator.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  config   | i_cfg_we                | i_cfg_idx, i_cfg_data (63 bits)
//  in       | i_in_valid / o_in_ready | i_first_x/y, i_second_x/y, i_last_item
//  out      | o_out_valid/i_out_ready | o_point_x/y/z, o_in_front, o_front_count,
//           |                         | o_end_of_set
//
// One request is processed at a time on a single 32x32 multiplier and accumulator:
// rays and Gram terms, block normalisation, the 2x2 system, sign handling, the two
// 31-step scale divisions (skipped when a scale is negative or the system is
// singular) and the point. The output register lets the next request in while a
// result waits. Reset is synchronous; it restores identity coefficients, a zero
// centre and clears the running count.
`default_nettype none

module two_view_midpoint_triangulator import tvm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CfgIdxW-1:0]       i_cfg_idx,
    input  logic [CfgW-1:0]          i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [PixW-1:0]          i_first_x,
    input  logic [PixW-1:0]          i_first_y,
    input  logic [PixW-1:0]          i_second_x,
    input  logic [PixW-1:0]          i_second_y,
    input  logic                     i_last_item,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [PointW-1:0] o_point_x,
    output logic signed [PointW-1:0] o_point_y,
    output logic signed [PointW-1:0] o_point_z,
    output logic                     o_in_front,
    output logic [CountW-1:0]        o_front_count,
    output logic                     o_end_of_set
);

    t_cmd cmd;
    t_sts sts;

    tvm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tvm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_first_x     (i_first_x),
        .i_first_y     (i_first_y),
        .i_second_x    (i_second_x),
        .i_second_y    (i_second_y),
        .i_last_item   (i_last_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_point_z     (o_point_z),
        .o_in_front    (o_in_front),
        .o_front_count (o_front_count),
        .o_end_of_set  (o_end_of_set)
    );

endmodule

`default_nettype wire

// ----- rtl/tvm_div.sv -----
// Restoring divider for the ray scales, one quotient bit per cycle.
`default_nettype none

module tvm_div import tvm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DivW-1:0]   i_num,
    input  logic [DivW-1:0]   i_den,
    output logic              o_done,
    output logic [PointW-1:0] o_quo
);

    logic [DivW:0]          r_rem;
    logic [DivW-1:0]        r_den;
    logic [DivSteps-1:0]    r_bits;
    logic [DivSteps-1:0]    r_quo;
    logic [DivCntW-1:0]     r_cnt;
    logic                   r_sat;
    logic                   r_busy;

    logic [DivW:0]          rem2;
    logic [DivW:0]          diff;
    logic                   ge;

    assign rem2 = {r_rem[DivW-1:0], r_bits[DivSteps-1]};
    assign ge   = rem2 >= {1'b0, r_den};
    assign diff = rem2 - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DivCntW'(DivSteps);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // the scale saturates to all ones once its integer part reaches 2^15
            r_sat  <= {{DivSatShift{1'b0}}, i_num} >= {i_den, {DivSatShift{1'b0}}};
            r_rem  <= (DivW + 1)'(i_num >> DivSatShift);
            r_bits <= {i_num[DivSatShift-1:0], {ScaleFrac{1'b0}}};
            r_den  <= i_den;
            r_quo  <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_rem  <= ge ? diff : rem2;
            r_bits <= {r_bits[DivSteps-2:0], 1'b0};
            r_quo  <= {r_quo[DivSteps-2:0], ge};
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quo  = r_sat ? {1'b0, {DivSteps{1'b1}}} : {1'b0, r_quo};

endmodule

`default_nettype wire

// ----- rtl/tvm_ctrl.sv -----
// Sequencer of the triangulator: steps the shared MAC, normalisation and division.
`default_nettype none

module tvm_ctrl import tvm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_MAC   = 11'b000_0000_0010,
        ST_WAIT  = 11'b000_0000_0100,
        ST_WRITE = 11'b000_0000_1000,
        ST_NINIT = 11'b000_0001_0000,
        ST_NORM  = 11'b000_0010_0000,
        ST_NEG   = 11'b000_0100_0000,
        ST_DCHK  = 11'b000_1000_0000,
        ST_DGO   = 11'b001_0000_0000,
        ST_DRUN  = 11'b010_0000_0000,
        ST_OUT   = 11'b100_0000_0000
    } t_state;

    t_state     r_state, n_state;
    t_seg       r_seg,   n_seg;
    logic [3:0] r_grp,   n_grp;
    logic [1:0] r_term,  n_term;
    logic       r_sel,   n_sel;

    logic [3:0] last_grp;
    logic [1:0] last_term;

    always_comb begin
        case (r_seg)
            SEG_GEOM: begin
                last_grp  = GeomLastGrp;
                last_term = GeomLastTerm;
            end
            SEG_SOLVE: begin
                last_grp  = SolveLastGrp;
                last_term = SolveLastTerm;
            end
            default: begin
                last_grp  = PointLastGrp;
                last_term = PointLastTerm;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_seg   = r_seg;
        n_grp   = r_grp;
        n_term  = r_term;
        n_sel   = r_sel;
        o_cmd      = '0;
        o_cmd.seg  = r_seg;
        o_cmd.grp  = r_grp;
        o_cmd.term = r_term;
        o_cmd.div_sel = r_sel;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_seg   = SEG_GEOM;
                    n_grp   = '0;
                    n_term  = '0;
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                o_cmd.mac_en = 1'b1;
                if (r_term == last_term) begin
                    n_term  = '0;
                    n_state = ST_WAIT;
                end else begin
                    n_term = r_term + 1'b1;
                end
            end
            ST_WAIT: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.wr_en = 1'b1;
                if (r_grp == last_grp) begin
                    case (r_seg)
                        SEG_GEOM:  n_state = ST_NINIT;
                        SEG_SOLVE: n_state = ST_NEG;
                        default:   n_state = ST_OUT;
                    endcase
                end else begin
                    n_grp   = r_grp + 1'b1;
                    n_state = ST_MAC;
                end
            end
            ST_NINIT: begin
                o_cmd.norm_init = 1'b1;
                n_state = ST_NORM;
            end
            ST_NORM: begin
                if (i_sts.norm_over) begin
                    o_cmd.norm_step = 1'b1;
                end else begin
                    n_seg   = SEG_SOLVE;
                    n_grp   = '0;
                    n_state = ST_MAC;
                end
            end
            ST_NEG: begin
                o_cmd.neg = 1'b1;
                n_state = ST_DCHK;
            end
            ST_DCHK: begin
                o_cmd.chk = 1'b1;
                if (i_sts.skip) begin
                    n_seg   = SEG_POINT;
                    n_grp   = '0;
                    n_state = ST_MAC;
                end else begin
                    n_sel   = 1'b0;
                    n_state = ST_DGO;
                end
            end
            ST_DGO: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_DRUN;
            end
            ST_DRUN: begin
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (!r_sel) begin
                        n_sel   = 1'b1;
                        n_state = ST_DGO;
                    end else begin
                        n_seg   = SEG_POINT;
                        n_grp   = '0;
                        n_state = ST_MAC;
                    end
                end
            end
            ST_OUT: begin
                // hold until the output register is free
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_seg   <= SEG_GEOM;
            r_grp   <= '0;
            r_term  <= '0;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seg   <= n_seg;
            r_grp   <= n_grp;
            r_term  <= n_term;
            r_sel   <= n_sel;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tvm_dp.sv -----
// Datapath: coefficient registers, shared multiplier and accumulator, divider, output stage.
`default_nettype none

module tvm_dp import tvm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  logic                     i_cfg_we,
    input  logic [CfgIdxW-1:0]       i_cfg_idx,
    input  logic [CfgW-1:0]          i_cfg_data,
    input  logic [PixW-1:0]          i_first_x,
    input  logic [PixW-1:0]          i_first_y,
    input  logic [PixW-1:0]          i_second_x,
    input  logic [PixW-1:0]          i_second_y,
    input  logic                     i_last_item,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [PointW-1:0] o_point_x,
    output logic signed [PointW-1:0] o_point_y,
    output logic signed [PointW-1:0] o_point_z,
    output logic                     o_in_front,
    output logic [CountW-1:0]        o_front_count,
    output logic                     o_end_of_set
);

    logic [CfgW-1:0]          r_cfg [NumCfg];
    logic [PixW-1:0]          r_p1x, r_p1y, r_p2x, r_p2y;
    logic                     r_last;
    logic signed [RayW-1:0]   r_d [6];
    logic signed [AccW-1:0]   r_g [5];
    logic signed [AccW-1:0]   r_num1, r_num2, r_det;
    logic signed [OpW-1:0]    r_s1, r_s2;
    logic signed [PointW-1:0] r_pt [3];
    logic                     r_front;
    logic [AccW-1:0]          r_nrm;
    logic signed [AccW-1:0]   r_prod;
    logic signed [AccW-1:0]   r_acc;
    logic                     r_acc_en, r_first, r_sub;
    logic [CountW-1:0]        r_count;

    logic signed [PointW-1:0] r_o_x, r_o_y, r_o_z;
    logic                     r_o_front, r_o_end, r_o_valid;
    logic [CountW-1:0]        r_o_count;

    logic signed [OpW-1:0]    op_a, op_b;
    logic signed [RayW-1:0]   d1t, d2t, d1g, d2g;
    logic signed [OpW-1:0]    ot, og;
    logic [2:0]               gidx;
    logic                     front;
    logic [CountW-1:0]        cnt_next;
    logic                     div_done;
    logic [PointW-1:0]        div_quo;

    function automatic logic signed [OpW-1:0] slot_of(input logic [CfgW-1:0] v,
                                                      input logic [1:0] k);
        logic signed [SlotW-1:0] u;
        case (k)
            2'd0:    u = v[SlotW-1:0];
            2'd1:    u = v[2*SlotW-1:SlotW];
            default: u = v[3*SlotW-1:2*SlotW];
        endcase
        return OpW'(u);
    endfunction

    function automatic logic signed [AccW-1:0] rnd(input logic signed [AccW-1:0] v,
                                                   input int n);
        logic signed [AccW-1:0] h;
        h = 1;
        h = h <<< n;
        h = h >>> 1;
        return (v + h) >>> n;
    endfunction

    function automatic logic signed [RayW-1:0] sat_ray(input logic signed [AccW-1:0] v);
        logic signed [RayW-1:0] r;
        if (v[AccW-1] && !(&v[AccW-1:RayW-1])) begin
            r = {1'b1, {(RayW-1){1'b0}}};
        end else if (!v[AccW-1] && (|v[AccW-1:RayW-1])) begin
            r = {1'b0, {(RayW-1){1'b1}}};
        end else begin
            r = v[RayW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [PointW-1:0] sat_pt(input logic signed [AccW-1:0] v);
        logic signed [PointW-1:0] r;
        if (v[AccW-1] && !(&v[AccW-1:PointW-1])) begin
            r = {1'b1, {(PointW-1){1'b0}}};
        end else if (!v[AccW-1] && (|v[AccW-1:PointW-1])) begin
            r = {1'b0, {(PointW-1){1'b1}}};
        end else begin
            r = v[PointW-1:0];
        end
        return r;
    endfunction

    function automatic logic [AccW-1:0] mag(input logic signed [AccW-1:0] v);
        return v[AccW-1] ? AccW'(-v) : AccW'(v);
    endfunction

    // operand selection for the shared multiplier
    always_comb begin
        case (i_cmd.term)
            2'd0: begin
                d1t = r_d[0];
                d2t = r_d[3];
            end
            2'd1: begin
                d1t = r_d[1];
                d2t = r_d[4];
            end
            default: begin
                d1t = r_d[2];
                d2t = r_d[5];
            end
        endcase
        case (i_cmd.grp[1:0])
            2'd0: begin
                d1g = r_d[0];
                d2g = r_d[3];
            end
            2'd1: begin
                d1g = r_d[1];
                d2g = r_d[4];
            end
            default: begin
                d1g = r_d[2];
                d2g = r_d[5];
            end
        endcase
        ot = slot_of(r_cfg[REG_CENTER], i_cmd.term);
        og = slot_of(r_cfg[REG_CENTER], i_cmd.grp[1:0]);
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (i_cmd.seg)
            SEG_GEOM: begin
                if (i_cmd.grp < GRP_GRAM_A) begin
                    op_a = slot_of(r_cfg[i_cmd.grp[2:0]], i_cmd.term);
                    case (i_cmd.term)
                        2'd0:    op_b = OpW'((i_cmd.grp < 4'd3) ? r_p1x : r_p2x);
                        2'd1:    op_b = OpW'((i_cmd.grp < 4'd3) ? r_p1y : r_p2y);
                        default: op_b = OpW'(PixOne);
                    endcase
                end else begin
                    case (i_cmd.grp)
                        GRP_GRAM_A: begin
                            op_a = OpW'(d1t);
                            op_b = OpW'(d1t);
                        end
                        GRP_GRAM_B: begin
                            op_a = OpW'(d1t);
                            op_b = OpW'(d2t);
                        end
                        GRP_GRAM_C: begin
                            op_a = OpW'(d2t);
                            op_b = OpW'(d2t);
                        end
                        GRP_DOT_E: begin
                            op_a = OpW'(d1t);
                            op_b = ot;
                        end
                        default: begin
                            op_a = OpW'(d2t);
                            op_b = ot;
                        end
                    endcase
                end
            end
            SEG_SOLVE: begin
                case (i_cmd.grp)
                    GRP_NUM1: begin
                        op_a = (i_cmd.term == 2'd0) ? r_g[2][OpW-1:0] : r_g[1][OpW-1:0];
                        op_b = (i_cmd.term == 2'd0) ? r_g[3][OpW-1:0] : r_g[4][OpW-1:0];
                    end
                    GRP_NUM2: begin
                        op_a = (i_cmd.term == 2'd0) ? r_g[1][OpW-1:0] : r_g[0][OpW-1:0];
                        op_b = (i_cmd.term == 2'd0) ? r_g[3][OpW-1:0] : r_g[4][OpW-1:0];
                    end
                    default: begin
                        op_a = (i_cmd.term == 2'd0) ? r_g[0][OpW-1:0] : r_g[1][OpW-1:0];
                        op_b = (i_cmd.term == 2'd0) ? r_g[2][OpW-1:0] : r_g[1][OpW-1:0];
                    end
                endcase
            end
            default: begin
                case (i_cmd.term)
                    2'd0: begin
                        op_a = OpW'(d1g);
                        op_b = r_s1;
                    end
                    2'd1: begin
                        op_a = OpW'(d2g);
                        op_b = r_s2;
                    end
                    default: begin
                        op_a = og;
                        op_b = OpW'(CenterScale);
                    end
                endcase
            end
        endcase
    end

    // multiply, then accumulate the registered product in the following cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= i_cmd.mac_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_en) begin
            r_prod  <= op_a * op_b;
            r_first <= (i_cmd.term == 2'd0);
            r_sub   <= (i_cmd.seg == SEG_SOLVE) && (i_cmd.term == 2'd1);
        end
        if (r_acc_en) begin
            if (r_first) begin
                r_acc <= r_prod;
            end else if (r_sub) begin
                r_acc <= r_acc - r_prod;
            end else begin
                r_acc <= r_acc + r_prod;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_RAY_ROW0]     <= RstRow0;
            r_cfg[REG_RAY_ROW1]     <= RstRow1;
            r_cfg[REG_RAY_ROW2]     <= RstRow2;
            r_cfg[REG_ROT_RAY_ROW0] <= RstRow0;
            r_cfg[REG_ROT_RAY_ROW1] <= RstRow1;
            r_cfg[REG_ROT_RAY_ROW2] <= RstRow2;
            r_cfg[REG_CENTER]       <= '0;
        end else if (i_cfg_we && i_cfg_idx <= REG_CENTER) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign gidx  = 3'(i_cmd.grp - GRP_GRAM_A);
    assign front = (r_det == '0) || (!r_num1[AccW-1] && !r_num2[AccW-1]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p1x  <= i_first_x;
            r_p1y  <= i_first_y;
            r_p2x  <= i_second_x;
            r_p2y  <= i_second_y;
            r_last <= i_last_item;
        end
        if (i_cmd.wr_en) begin
            case (i_cmd.seg)
                SEG_GEOM: begin
                    if (i_cmd.grp < GRP_GRAM_A) begin
                        r_d[i_cmd.grp[2:0]] <= sat_ray(rnd(r_acc, RayShift));
                    end else if (i_cmd.grp < GRP_DOT_E) begin
                        r_g[gidx] <= r_acc;
                    end else begin
                        r_g[gidx] <= rnd(r_acc, EfShift);
                    end
                end
                SEG_SOLVE: begin
                    case (i_cmd.grp)
                        GRP_NUM1: r_num1 <= r_acc;
                        GRP_NUM2: r_num2 <= r_acc;
                        default:  r_det  <= r_acc;
                    endcase
                end
                default: begin
                    r_pt[i_cmd.grp[1:0]] <= sat_pt(rnd(r_acc, PointShift));
                end
            endcase
        end
        if (i_cmd.norm_init) begin
            r_nrm <= mag(r_g[0]) | mag(r_g[1]) | mag(r_g[2]) | mag(r_g[3]) | mag(r_g[4]);
        end
        if (i_cmd.norm_step) begin
            r_nrm <= r_nrm >> 1;
            for (int i = 0; i < 5; i++) begin
                r_g[i] <= r_g[i] >>> 1;
            end
        end
        if (i_cmd.neg && r_det[AccW-1]) begin
            r_det  <= -r_det;
            r_num1 <= -r_num1;
            r_num2 <= -r_num2;
        end
        if (i_cmd.chk) begin
            r_front <= front;
            r_s1    <= '0;
            r_s2    <= '0;
        end
        if (i_cmd.div_store) begin
            if (i_cmd.div_sel) begin
                r_s2 <= div_quo;
            end else begin
                r_s1 <= div_quo;
            end
        end
    end

    tvm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (i_cmd.div_sel ? r_num2[DivW-1:0] : r_num1[DivW-1:0]),
        .i_den   (r_det[DivW-1:0]),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign cnt_next = (r_front && r_count != '1) ? r_count + 1'b1 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_count   <= '0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
            r_count   <= r_last ? '0 : cnt_next;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_x     <= r_front ? r_pt[0] : '0;
            r_o_y     <= r_front ? r_pt[1] : '0;
            r_o_z     <= r_front ? r_pt[2] : '0;
            r_o_front <= r_front;
            r_o_count <= cnt_next;
            r_o_end   <= r_last;
        end
    end

    assign o_sts.norm_over = |r_nrm[AccW-1:NormBits];
    assign o_sts.skip      = (r_det == '0) || r_num1[AccW-1] || r_num2[AccW-1];
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = !r_o_valid || i_out_ready;

    assign o_out_valid   = r_o_valid;
    assign o_point_x     = r_o_x;
    assign o_point_y     = r_o_y;
    assign o_point_z     = r_o_z;
    assign o_in_front    = r_o_front;
    assign o_front_count = r_o_count;
    assign o_end_of_set  = r_o_end;

endmodule

`default_nettype wire

// ----- rtl/tvm_check.sv -----
// Port-level checker for the triangulator, bound to the top level.
`default_nettype none

module tvm_check import tvm_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic signed [PointW-1:0] o_point_x,
    input logic signed [PointW-1:0] o_point_y,
    input logic signed [PointW-1:0] o_point_z,
    input logic                     o_in_front,
    input logic [CountW-1:0]        o_front_count
);

    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while busy");

    a_behind_is_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_front |->
            o_point_x == '0 && o_point_y == '0 && o_point_z == '0)
        else $error("point behind camera not at origin");

    a_front_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_in_front |-> o_front_count != '0)
        else $error("front point missing from count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_point_x) && $stable(o_front_count))
        else $error("stalled result changed");

endmodule

bind two_view_midpoint_triangulator tvm_check u_tvm_check (.*);

`default_nettype wire
